// ===== rtl/clr_pkg.sv =====
`default_nettype none
package clr_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int ENTRY_W  = 31;
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic [ENTRY_W-1:0] entry_at_position;
        logic               append_dropped;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/compacting_list_remove_at_top.sv =====
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_data  (command, value, position)
// m_      | out       | m_valid / m_ready  | m_data  (entry_count, entry_at_position,
//         |           |                    |          append_dropped)
//
// for each item the cell row updates at the accepting edge, and the result is read
// out of the row into the output register once that register is free
// s_ready is low for the cycle after a transfer, and stays low while the previous
// result still blocks the output register
// aresetn clears the count and the handshake state; the cells are not reset
`default_nettype none
module compacting_list_remove_at_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  clr_pkg::in_item_t      s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output clr_pkg::out_item_t           m_data
);
    import clr_pkg::*;

    logic [ENTRY_W-1:0] cell_value [CAPACITY];
    cell_ctrl_t         cell_ctrl  [CAPACITY];

    logic [COUNT_W-1:0] count_reg, count_next;
    logic               pend_reg, pend_next;
    logic [POS_W-1:0]   pos_reg;
    logic               drop_reg;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg;

    logic               accept;
    logic               is_append, is_remove, full, empty;
    logic [COUNT_W-1:0] last;
    logic [CMP_W-1:0]   pos_ext, last_ext, gap, count_ext;
    logic [ENTRY_W-1:0] clamped;
    logic               load_out;
    logic [CMP_W-1:0]   pend_pos_ext;
    logic [ENTRY_W-1:0] shown;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !pend_reg;
    assign is_append = (s_data.command == CMD_APPEND);
    assign is_remove = (s_data.command == CMD_REMOVE);
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign last      = count_reg - COUNT_W'(1);
    assign pos_ext   = CMP_W'(s_data.position);
    assign last_ext  = CMP_W'(last);
    assign count_ext = CMP_W'(count_reg);
    assign gap       = (pos_ext < last_ext) ? pos_ext : last_ext;
    assign clamped   = s_data.value[VALUE_W-1] ? '0 : s_data.value[ENTRY_W-1:0];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ENTRY_W-1:0] nb;
        if (i == CAPACITY - 1) begin : g_end
            assign nb = '0;
        end else begin : g_mid
            assign nb = cell_value[i+1];
        end

        assign cell_ctrl[i].load  = accept && is_append && (count_ext == CMP_W'(i));
        assign cell_ctrl[i].shift = accept && is_remove && !empty
                                    && (CMP_W'(i) >= gap) && (CMP_W'(i) < last_ext);

        clr_cell u_cell (
            .aclk           (aclk),
            .ctrl           (cell_ctrl[i]),
            .load_value     (clamped),
            .neighbor_value (nb),
            .value          (cell_value[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        if (accept && is_append && !full) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (accept && is_remove && !empty) begin
            count_next = last;
        end
    end

    assign load_out     = pend_reg && (!m_valid_reg || m_ready);
    assign pend_pos_ext = CMP_W'(pos_reg);
    assign shown        = (pend_pos_ext < count_ext)
                          ? cell_value[pend_pos_ext[IDX_W-1:0]] : '0;

    always_comb begin
        pend_next = pend_reg;
        if (accept) begin
            pend_next = 1'b1;
        end else if (load_out) begin
            pend_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg  <= s_data.position;
            drop_reg <= is_append && full;
        end
        if (load_out) begin
            m_data_reg.entry_count       <= count_reg;
            m_data_reg.entry_at_position <= shown;
            m_data_reg.append_dropped    <= drop_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== rtl/clr_cell.sv =====
`default_nettype none
module clr_cell (
    input  wire                           aclk,
    input  wire  clr_pkg::cell_ctrl_t     ctrl,
    input  wire  [clr_pkg::ENTRY_W-1:0]   load_value,
    input  wire  [clr_pkg::ENTRY_W-1:0]   neighbor_value,
    output logic [clr_pkg::ENTRY_W-1:0]   value
);
    import clr_pkg::*;

    logic [ENTRY_W-1:0] value_reg;
    logic [ENTRY_W-1:0] value_next;

    always_comb begin
        priority if (ctrl.load) begin
            value_next = load_value;
        end else if (ctrl.shift) begin
            value_next = neighbor_value;
        end else begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
`default_nettype wire

// ===== rtl/clr_checker.sv =====
`default_nettype none
module clr_checker (
    input wire                      aclk,
    input wire                      aresetn,
    input wire                      s_valid,
    input wire                      s_ready,
    input wire clr_pkg::in_item_t   s_data,
    input wire                      m_valid,
    input wire                      m_ready,
    input wire clr_pkg::out_item_t  m_data
);
    import clr_pkg::*;

    logic unused_in;
    assign unused_in = ^s_data;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted before result formed");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.entry_count <= COUNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.append_dropped |-> m_data.entry_count == COUNT_W'(CAPACITY))
        else $error("append dropped while not full");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.entry_count == '0 |-> m_data.entry_at_position == '0)
        else $error("entry shown from empty list");

endmodule

bind compacting_list_remove_at_top clr_checker u_clr_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
    import clr_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        in_item_t  cmd;
        bit        typed;
        out_item_t want;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    logic [ENTRY_W-1:0] shadow_entries [CAPACITY];
    int unsigned        shadow_count = 0;
    out_item_t          expected_results [$];
    stim_row_t          directed_rows [$];

    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    int fill_bias = 50;
    int mismatch_count = 0;
    int cycle_count = 0;

    compacting_list_remove_at_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic out_item_t apply_list_command(input in_item_t it);
        out_item_t   r;
        int unsigned pos;
        int unsigned last;
        int unsigned gap;
        int unsigned i;
        r = '0;
        pos = it.position;
        case (it.command)
            CMD_APPEND: begin
                if (shadow_count >= CAPACITY) begin
                    r.append_dropped = 1'b1;
                end else begin
                    shadow_entries[shadow_count] = it.value[VALUE_W-1] ? '0 : it.value[ENTRY_W-1:0];
                    shadow_count++;
                end
            end
            CMD_REMOVE: begin
                if (shadow_count > 0) begin
                    last = shadow_count - 1;
                    gap = (pos < last) ? pos : last;
                    for (i = gap; i < last; i++) begin
                        shadow_entries[i] = shadow_entries[i + 1];
                    end
                    shadow_count = last;
                end
            end
            default: ;
        endcase
        r.entry_count = COUNT_W'(shadow_count);
        if (pos < shadow_count) begin
            r.entry_at_position = shadow_entries[pos];
        end
        return r;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] c, input logic [31:0] v,
                                           input logic [3:0] p);
        in_item_t it;
        it.command = c;
        it.value = v;
        it.position = p;
        return it;
    endfunction

    function automatic void add_row(input logic [1:0] c, input logic [31:0] v,
                                    input logic [3:0] p, input bit typed,
                                    input int unsigned cnt, input logic [30:0] ent,
                                    input bit drop);
        stim_row_t row;
        row.cmd = make_item(c, v, p);
        row.typed = typed;
        row.want.entry_count = COUNT_W'(cnt);
        row.want.entry_at_position = ent;
        row.want.append_dropped = drop;
        directed_rows.push_back(row);
    endfunction

    function automatic in_item_t random_command();
        logic [1:0]  c;
        logic [31:0] v;
        int unsigned p;
        int unsigned lim;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            c = CMD_UNUSED;
        end else if (r < 16) begin
            c = CMD_READ;
        end else if ($urandom_range(0, 99) < fill_bias) begin
            c = CMD_APPEND;
        end else begin
            c = CMD_REMOVE;
        end
        case ($urandom_range(0, 7))
            0: v = 32'h0000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1) == 0) begin
            p = $urandom_range(0, 15);
        end else begin
            lim = (shadow_count > 15) ? 15 : shadow_count;
            p = $urandom_range(0, lim);
        end
        return make_item(c, v, p[3:0]);
    endfunction

    task automatic note_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
        if (mismatch_count < 10) begin
            $display("%s: count exp %0d got %0d, entry exp %h got %h, dropped exp %b got %b",
                     what, want.entry_count, got.entry_count, want.entry_at_position,
                     got.entry_at_position, want.append_dropped, got.append_dropped);
        end
        mismatch_count++;
    endtask

    task automatic check_list_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            note_mismatch("transfer with nothing expected", '0, got);
            return;
        end
        want = expected_results.pop_front();
        if (got.entry_count !== want.entry_count
                || got.entry_at_position !== want.entry_at_position
                || got.append_dropped !== want.append_dropped) begin
            note_mismatch("result mismatch", want, got);
        end
    endtask

    // result side: check, then decide ready for the next edge
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_list_result(m_data);
            end
            if (sink_hold_left > 0) begin
                m_ready <= 1'b0;
                sink_hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    task automatic offer_command(input in_item_t it, input bit typed, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(0, 99) < source_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = apply_list_command(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input int idle_pct, input int stall_pct);
        int n;
        source_idle_pct = idle_pct;
        sink_stall_pct = stall_pct;
        for (n = 0; n < count; n++) begin
            if (n % 48 == 0) begin
                case ($urandom_range(0, 2))
                    0: fill_bias = 80;
                    1: fill_bias = 20;
                    default: fill_bias = 50;
                endcase
            end
            offer_command(random_command(), 1'b0, '0);
        end
    endtask

    initial begin
        int k;
        // empty list corner cases
        add_row(CMD_READ,   32'h0000_0000, 4'd0,  1'b1, 0, 31'h0, 1'b0);
        add_row(CMD_REMOVE, 32'h0000_0000, 4'd5,  1'b1, 0, 31'h0, 1'b0);
        add_row(CMD_UNUSED, 32'hFFFF_FFFF, 4'd0,  1'b1, 0, 31'h0, 1'b0);
        // value extremes and clamping
        add_row(CMD_APPEND, 32'h7FFF_FFFF, 4'd0,  1'b1, 1, 31'h7FFF_FFFF, 1'b0);
        add_row(CMD_APPEND, 32'hFFFF_FFFF, 4'd1,  1'b1, 2, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h8000_0000, 4'd2,  1'b1, 3, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h0000_0000, 4'd15, 1'b1, 4, 31'h0, 1'b0);
        // fill to capacity
        add_row(CMD_APPEND, 32'h5555_5555, 4'd4,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h2AAA_AAAA, 4'd5,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h0000_0001, 4'd3,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h4000_0000, 4'd7,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h7FFF_FFFE, 4'd8,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'hC000_0000, 4'd9,  1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h1234_5678, 4'd10, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h0F0F_0F0F, 4'd12, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h7000_0000, 4'd12, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h0000_FFFF, 4'd13, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h3FFF_FFFF, 4'd14, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_APPEND, 32'h6543_2100, 4'd15, 1'b0, 0, 31'h0, 1'b0);
        // append when full is refused
        add_row(CMD_APPEND, 32'h0000_0001, 4'd0,  1'b1, 16, 31'h7FFF_FFFF, 1'b1);
        add_row(CMD_READ,   32'h0000_0000, 4'd15, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_REMOVE, 32'h0000_0000, 4'd15, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_REMOVE, 32'h0000_0000, 4'd0,  1'b0, 0, 31'h0, 1'b0);
        // remove past the end takes the last entry
        add_row(CMD_REMOVE, 32'hFFFF_FFFF, 4'd15, 1'b0, 0, 31'h0, 1'b0);
        add_row(CMD_UNUSED, 32'h0000_0000, 4'd3,  1'b0, 0, 31'h0, 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        source_idle_pct = 0;
        sink_stall_pct = 0;
        for (k = 0; k < directed_rows.size(); k++) begin
            offer_command(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want);
        end
        wait_drained();

        run_random(PHASE_ITEMS, 0, 0);
        wait_drained();
        run_random(PHASE_ITEMS, 51, 0);
        wait_drained();
        run_random(PHASE_ITEMS, 0, 51);
        wait_drained();
        run_random(PHASE_ITEMS, 14, 14);
        wait_drained();

        // long receiver hold-off while the sender keeps pushing
        sink_hold_left = 80;
        run_random(40, 0, 0);
        wait_drained();

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
